// ===== hdl/smt_pkg.sv =====
// Shared sizing constants and codes for the sorted multiset table.
`timescale 1ns / 1ps
package smt_pkg;

  localparam int DEPTH  = 256;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  // Action codes, carried in in_tuser
  localparam logic [2:0] ACT_INSERT    = 3'd0;
  localparam logic [2:0] ACT_DEL_VALUE = 3'd1;
  localparam logic [2:0] ACT_DEL_RANGE = 3'd2;
  localparam logic [2:0] ACT_CLEAR     = 3'd3;
  localparam logic [2:0] ACT_READ      = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

endpackage

// ===== hdl/smt_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module smt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/sorted_multiset_table.sv =====
// Sorted multiset table: ascending store of signed Q16.16 values in one RAM.
// An insert shifts each larger entry up one slot before it writes the value, a delete
// streams every entry through compaction, a read fetches one entry from the RAM.
// One beat in flight; one entry a cycle when compacting.
// Reset (rst_n low, synchronous) empties the table and drops any pending result;
// the RAM itself is not cleared, only entries below the count are ever read.
`timescale 1ns / 1ps
module sorted_multiset_table
  import smt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // Input beats
  input  logic         in_tvalid,
  output logic         in_tready,
  // value[31:0], delete_every[32], range_low[64:33], range_high[96:65],
  // read_index[104:97], zero pad[111:105]
  input  logic [111:0] in_tdata,
  // action[2:0]
  input  logic [2:0]   in_tuser,
  // Result beats
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[1:0], entries_held[10:2], removed_count[19:11], read_value[51:20],
  // zero pad[55:52]
  output logic [55:0]  out_tdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,   // fetch entry below the insert point
    S_INS_CHK,  // shift it up, or drop the new value in
    S_INS_PUT,  // write the new value at the bottom
    S_CMP,      // streaming compaction, one entry a cycle
    S_RD,       // fetch entry for a read
    S_RDW,      // capture read data
    S_FIN       // hand result to the output register
  } state_t;

  state_t             state_r;
  logic [CW-1:0]      count_r;

  // Latched beat
  logic signed [DATA_W-1:0] value_r;
  logic signed [DATA_W-1:0] lo_r;
  logic signed [DATA_W-1:0] hi_r;
  logic                     every_r;
  logic                     range_mode_r;
  logic [AW-1:0]            idx_r;

  // Walk pointers
  logic [AW-1:0]      pos_r;
  logic [CW-1:0]      rd_ptr_r;
  logic [CW-1:0]      wr_ptr_r;
  logic [CW-1:0]      gone_r;
  logic               pend_r;

  // Result being built
  logic [1:0]               res_status_r;
  logic [CW-1:0]            res_removed_r;
  logic signed [DATA_W-1:0] res_readv_r;

  // Output register
  logic                     out_valid_r;
  logic [1:0]               out_status_r;
  logic [CW-1:0]            out_held_r;
  logic [CW-1:0]            out_removed_r;
  logic signed [DATA_W-1:0] out_readv_r;

  // RAM ports
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [DATA_W-1:0]   ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [DATA_W-1:0]   ram_rdata;
  logic signed [DATA_W-1:0] rd_val;

  logic rd_gt;
  logic drop;
  logic in_beat;
  logic can_emit;

  smt_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_val   = $signed(ram_rdata);
  assign rd_gt    = rd_val > value_r;
  // Range mode drops lo..hi (an inverted range matches nothing); value mode
  // drops equal entries, only the first unless every match is asked for.
  assign drop     = range_mode_r ? ((rd_val >= lo_r) && (rd_val <= hi_r))
                                 : ((rd_val == value_r) && (every_r || (gone_r == '0)));

  assign in_tready = (state_r == S_IDLE);
  assign in_beat   = in_tvalid && in_tready;
  assign can_emit  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_readv_r, out_removed_r, out_held_r, out_status_r};

  // RAM access per state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos_r;
    ram_wdata = value_r;
    ram_raddr = pos_r - 1'b1;
    unique case (state_r)
      S_INS_CHK: begin
        ram_we    = 1'b1;
        ram_wdata = rd_gt ? ram_rdata : value_r;
      end
      S_INS_PUT: begin
        ram_we = 1'b1;
      end
      S_CMP: begin
        // write slot never passes the read slot, so no overlap
        ram_raddr = rd_ptr_r[AW-1:0];
        ram_we    = pend_r && !drop;
        ram_waddr = wr_ptr_r[AW-1:0];
        ram_wdata = ram_rdata;
      end
      S_RD: begin
        ram_raddr = idx_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // in S_FIN the output register is reloaded whenever it can take a beat
      if (out_tready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_beat) begin
            value_r       <= $signed(in_tdata[31:0]);
            every_r       <= in_tdata[32];
            lo_r          <= $signed(in_tdata[64:33]);
            hi_r          <= $signed(in_tdata[96:65]);
            idx_r         <= in_tdata[104:97];
            res_status_r  <= ST_DONE;
            res_removed_r <= '0;
            res_readv_r   <= '0;
            rd_ptr_r      <= '0;
            wr_ptr_r      <= '0;
            gone_r        <= '0;
            pend_r        <= 1'b0;
            range_mode_r  <= (in_tuser == ACT_DEL_RANGE);
            unique case (in_tuser) inside
              ACT_INSERT: begin
                if (count_r == CW'(DEPTH)) begin
                  res_status_r <= ST_FULL;
                  state_r      <= S_FIN;
                end else begin
                  pos_r   <= count_r[AW-1:0];
                  state_r <= (count_r == '0) ? S_INS_PUT : S_INS_RD;
                end
              end
              ACT_DEL_VALUE, ACT_DEL_RANGE: begin
                state_r <= S_CMP;
              end
              ACT_CLEAR: begin
                res_removed_r <= count_r;
                count_r       <= '0;
                state_r       <= S_FIN;
              end
              ACT_READ: begin
                if ({1'b0, in_tdata[104:97]} < count_r) begin
                  state_r <= S_RD;
                end else begin
                  res_status_r <= ST_MISS;
                  state_r      <= S_FIN;
                end
              end
              default: begin
                res_status_r <= ST_MISS;
                state_r      <= S_FIN;
              end
            endcase
          end
        end
        S_INS_RD: begin
          state_r <= S_INS_CHK;
        end
        S_INS_CHK: begin
          if (rd_gt) begin
            // entry moved up one slot; new value goes below it
            pos_r   <= pos_r - 1'b1;
            state_r <= (pos_r == AW'(1)) ? S_INS_PUT : S_INS_RD;
          end else begin
            count_r <= count_r + 1'b1;
            state_r <= S_FIN;
          end
        end
        S_INS_PUT: begin
          count_r <= count_r + 1'b1;
          state_r <= S_FIN;
        end
        S_CMP: begin
          if (rd_ptr_r != count_r) begin
            rd_ptr_r <= rd_ptr_r + 1'b1;
            pend_r   <= 1'b1;
          end else begin
            pend_r <= 1'b0;
          end
          if (pend_r) begin
            if (drop) begin
              gone_r <= gone_r + 1'b1;
            end else begin
              wr_ptr_r <= wr_ptr_r + 1'b1;
            end
          end
          if ((rd_ptr_r == count_r) && !pend_r) begin
            count_r       <= wr_ptr_r;
            res_removed_r <= gone_r;
            res_status_r  <= (gone_r == '0) ? ST_MISS : ST_DONE;
            state_r       <= S_FIN;
          end
        end
        S_RD: begin
          state_r <= S_RDW;
        end
        S_RDW: begin
          res_readv_r <= rd_val;
          state_r     <= S_FIN;
        end
        S_FIN: begin
          if (can_emit) begin
            out_valid_r   <= 1'b1;
            out_status_r  <= res_status_r;
            out_held_r    <= count_r;
            out_removed_r <= res_removed_r;
            out_readv_r   <= res_readv_r;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // The table never holds more than DEPTH entries
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count beyond table depth");

  // Compaction write slot must never overtake the read slot
  a_cmp_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (wr_ptr_r <= rd_ptr_r))
    else $error("compaction write pointer passed read pointer");

  // A refused insert only ever reports a full table
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_FULL)) |-> (out_held_r == CW'(DEPTH)))
    else $error("full status with free entries");

  // Table count only changes while an item is being worked on
  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FIN) && $past(state_r == S_FIN)) |-> $stable(count_r))
    else $error("entry count moved while waiting to emit");

endmodule
